>>> sv/rcpc_pkg.sv
// Shared constants, codes and types of the RC pulse capture block.
package rcpc_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    REG_CENTER    = 3'd0,
    REG_DIVISOR   = 3'd1,
    REG_DEADBAND  = 3'd2,
    REG_THR_MIN   = 3'd3,
    REG_THR_CHAN  = 3'd4,
    REG_AUX_CHAN  = 3'd5,
    REG_TIMEOUT   = 3'd6
  } cfg_reg_e;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_THR_LOST = 2'd1;
  localparam logic [1:0] STAT_AUX_LOST = 2'd2;

  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

>>> sv/rcpc_if.sv
// Valid/ready channel interfaces for edge/query items and for results.
interface rcpc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [2:0]  channel;
  logic        level;
  logic [15:0] fine_time;
  logic [15:0] coarse_time;

  modport source (output valid, mode, channel, level, fine_time, coarse_time, input ready);
  modport sink (input valid, mode, channel, level, fine_time, coarse_time, output ready);
endinterface

interface rcpc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic signed [15:0] value;
  logic [15:0]        raw_width;
  logic [1:0]         status;

  modport source (output valid, out_channel, value, raw_width, status, input ready);
  modport sink (input valid, out_channel, value, raw_width, status, output ready);
endinterface

>>> sv/rc_pulse_capture_failsafe.sv
// Top level of the RC pulse-width capture block with signal-lost failsafe.
// An edge item is taken and gives no result: a rising level stores
// the fine time, a falling level stores the pulse width and stamps the coarse
// time for the throttle and aux-watch channels. A query item checks both
// signal-lost timeouts and, when the signal is present, scales the offset
// width through a bit-serial divider that forms the quotient one bit at a time
// and then moves it to the result register once the result channel is free;
// a lost signal or unused channel skips the divider and goes straight to that step.
// The input is not ready while a query is in work; a finished result waits in
// an output register so the next item can be taken meanwhile.
module rc_pulse_capture_failsafe (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  rcpc_in_if.sink     req,
  rcpc_out_if.source  rsp
);
  import rcpc_pkg::*;

  logic [15:0] center_ticks;
  logic [7:0]  divisor;
  logic [7:0]  deadband;
  logic [15:0] throttle_min;
  logic [2:0]  throttle_channel;
  logic [2:0]  aux_watch_channel;
  logic [15:0] lost_timeout;

  logic [15:0] rise_time [CHANNELS];
  logic [15:0] pulse_width [CHANNELS];
  logic [15:0] last_throttle_seen;
  logic [15:0] last_aux_seen;

  state_t state;
  state_t state_next;

  logic [2:0]  q_ch;
  logic [15:0] q_w;
  logic [1:0]  q_status;
  logic        q_thr;
  logic        q_neg;
  logic        q_zero;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             take;
  logic             ch_valid;
  logic [CH_W-1:0]  idx;
  logic [15:0]      since_thr;
  logic [15:0]      since_aux;
  logic [1:0]       status_now;
  logic [15:0]      w_now;
  logic             thr_now;
  logic signed [16:0] diff;
  logic [15:0]      mag;
  logic signed [16:0] qs;
  logic signed [16:0] db;
  logic signed [15:0] val_fin;
  logic             out_free;

  assign req.ready = (state == S_IDLE);
  assign take      = req.valid && req.ready;
  assign ch_valid  = 32'(req.channel) < CHANNELS;
  assign idx       = CH_W'(req.channel);
  assign out_free  = !rsp.valid || rsp.ready;

  assign since_thr = req.coarse_time - last_throttle_seen;
  assign since_aux = req.coarse_time - last_aux_seen;
  assign thr_now   = req.channel == throttle_channel;
  assign w_now     = ch_valid ? pulse_width[idx] : 16'd0;

  always_comb begin
    priority if (since_thr > lost_timeout) status_now = STAT_THR_LOST;
    else if (since_aux > lost_timeout)     status_now = STAT_AUX_LOST;
    else                                   status_now = STAT_OK;
  end

  assign diff = $signed({1'b0, w_now}) - $signed({1'b0, thr_now ? throttle_min : center_ticks});
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  assign div_req.start    = take && (req.mode == MODE_QUERY) && ch_valid
                            && (status_now == STAT_OK);
  assign div_req.dividend = mag;
  assign div_req.divisor  = divisor;

  rcpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign qs = q_neg ? 17'(-$signed({1'b0, div_rsp.quotient}))
                    : $signed({1'b0, div_rsp.quotient});
  assign db = $signed({9'd0, deadband});

  always_comb begin
    priority if (q_zero)                          val_fin = 16'sd0;
    else if (qs > 17'sd32767)                     val_fin = 16'sh7fff;
    else if (qs < -17'sd32768)                    val_fin = 16'sh8000;
    else if (!q_thr && qs < db && qs > -db)       val_fin = 16'sd0;
    else                                          val_fin = qs[15:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && req.mode == MODE_QUERY) begin
          state_next = div_req.start ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      center_ticks      <= 16'd3000;
      divisor           <= 8'd1;
      deadband          <= 8'd0;
      throttle_min      <= 16'd2000;
      throttle_channel  <= 3'd0;
      aux_watch_channel <= 3'd1;
      lost_timeout      <= 16'd20;
      last_throttle_seen <= '0;
      last_aux_seen      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time[i]   <= '0;
        pulse_width[i] <= '0;
      end
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER:   center_ticks      <= cfg_data;
          REG_DIVISOR:  divisor           <= cfg_data[7:0];
          REG_DEADBAND: deadband          <= cfg_data[7:0];
          REG_THR_MIN:  throttle_min      <= cfg_data;
          REG_THR_CHAN: throttle_channel  <= cfg_data[2:0];
          REG_AUX_CHAN: aux_watch_channel <= cfg_data[2:0];
          REG_TIMEOUT:  lost_timeout      <= cfg_data;
          default: ;
        endcase
      end
      if (take && req.mode == MODE_EDGE && ch_valid) begin
        if (req.level) begin
          rise_time[idx] <= req.fine_time;
        end else begin
          pulse_width[idx] <= req.fine_time - rise_time[idx];
          if (req.channel == throttle_channel) begin
            last_throttle_seen <= req.coarse_time;
          end
          if (req.channel == aux_watch_channel) begin
            last_aux_seen <= req.coarse_time;
          end
        end
      end
      if (state == S_FIN && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.mode == MODE_QUERY) begin
      q_ch     <= req.channel;
      q_w      <= w_now;
      q_status <= status_now;
      q_thr    <= thr_now;
      q_neg    <= diff[16];
      q_zero   <= !div_req.start;
    end
    if (state == S_FIN && out_free) begin
      rsp.out_channel <= q_ch;
      rsp.value       <= val_fin;
      rsp.raw_width   <= q_w;
      rsp.status      <= q_status;
    end
  end

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.mode == MODE_QUERY |=> !req.ready)
    else $error("Input ready right after a query transfer.");

  a_lost_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != STAT_OK |-> rsp.value == 16'sd0)
    else $error("Nonzero value reported with a lost signal.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status <= STAT_AUX_LOST)
    else $error("Undefined status code on the result.");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("Divider finished outside the divide state.");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> state == S_IDLE)
    else $error("Divider started while a query is in work.");

endmodule

>>> sv/rcpc_div.sv
// Bit-serial restoring divider: 16-bit magnitude by 8-bit divisor, one bit per cycle.
module rcpc_div (
  input  logic              clk,
  input  logic              rst,
  input  rcpc_pkg::div_req_t req,
  output rcpc_pkg::div_rsp_t rsp
);
  import rcpc_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      dvd;
  logic [7:0]       dvs;
  logic [7:0]       rem;
  logic [8:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem, dvd[15]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= (req.divisor == 8'd0) ? 8'd1 : req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];
      dvd <= {dvd[14:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

>>> tb/sv/rcpc_checker.sv
// Checker for the RC pulse capture block: predicts each query result and compares it.
`timescale 1ns / 100ps
module rcpc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  rcpc_in_if          req,
  rcpc_out_if         rsp,
  output int          fails,
  output int          pending
);
  import rcpc_pkg::*;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [15:0] value;
    logic [15:0]        raw;
    logic [1:0]         status;
  } reading_t;

  logic [15:0] center_ticks;
  logic [7:0]  div_reg;
  logic [7:0]  dead_reg;
  logic [15:0] thr_min;
  logic [2:0]  thr_ch;
  logic [2:0]  aux_ch;
  logic [15:0] timeout;

  logic [15:0] rise_at [CHANNELS];
  logic [15:0] width [CHANNELS];
  logic [15:0] thr_seen;
  logic [15:0] aux_seen;

  reading_t readings_due [$];
  int       err_cnt = 0;

  function automatic int scale(int offset);
    int d;
    int q;
    d = (div_reg == 8'd0) ? 1 : int'(div_reg);
    q = offset / d;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic reading_t read_stick(logic [2:0] ch, logic [15:0] coarse);
    reading_t    r;
    logic [15:0] since_thr;
    logic [15:0] since_aux;
    int          v;
    bit          known;
    known = int'(ch) < CHANNELS;
    since_thr = coarse - thr_seen;
    since_aux = coarse - aux_seen;
    r.chan = ch;
    r.raw = known ? width[ch] : 16'd0;
    if (since_thr > timeout) r.status = STAT_THR_LOST;
    else if (since_aux > timeout) r.status = STAT_AUX_LOST;
    else r.status = STAT_OK;
    v = 0;
    if (r.status == STAT_OK && known) begin
      if (ch == thr_ch) begin
        v = scale(int'(r.raw) - int'(thr_min));
      end else begin
        v = scale(int'(r.raw) - int'(center_ticks));
        if (v < int'(dead_reg) && v > -int'(dead_reg)) v = 0;
      end
    end
    r.value = v[15:0];
    return r;
  endfunction

  function automatic void capture_edge(logic [2:0] ch, logic level, logic [15:0] fine,
                                       logic [15:0] coarse);
    if (int'(ch) >= CHANNELS) return;
    if (level) begin
      rise_at[ch] = fine;
    end else begin
      width[ch] = fine - rise_at[ch];
      if (ch == thr_ch) thr_seen = coarse;
      if (ch == aux_ch) aux_seen = coarse;
    end
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      center_ticks = 16'd3000;
      div_reg = 8'd1;
      dead_reg = 8'd0;
      thr_min = 16'd2000;
      thr_ch = 3'd0;
      aux_ch = 3'd1;
      timeout = 16'd20;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_at[i] = 16'd0;
        width[i] = 16'd0;
      end
      thr_seen = 16'd0;
      aux_seen = 16'd0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER:   center_ticks = cfg_data;
          REG_DIVISOR:  div_reg = cfg_data[7:0];
          REG_DEADBAND: dead_reg = cfg_data[7:0];
          REG_THR_MIN:  thr_min = cfg_data;
          REG_THR_CHAN: thr_ch = cfg_data[2:0];
          REG_AUX_CHAN: aux_ch = cfg_data[2:0];
          REG_TIMEOUT:  timeout = cfg_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (readings_due.size() == 0) begin
          $error("result on channel %0d with no query waiting", rsp.out_channel);
          err_cnt++;
        end else begin
          want = readings_due.pop_front();
          if (rsp.out_channel !== want.chan) begin
            $error("out_channel: expected %0d, got %0d", want.chan, rsp.out_channel);
            err_cnt++;
          end
          if (rsp.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(rsp.value));
            err_cnt++;
          end
          if (rsp.raw_width !== want.raw) begin
            $error("raw_width: expected %0d, got %0d", want.raw, rsp.raw_width);
            err_cnt++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_cnt++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.mode == MODE_QUERY) begin
          readings_due.push_back(read_stick(req.channel, req.coarse_time));
        end else begin
          capture_edge(req.channel, req.level, req.fine_time, req.coarse_time);
        end
      end
    end
    fails <= err_cnt;
    pending <= readings_due.size();
  end

endmodule

>>> tb/sv/tb.sv
// Top of the testbench: clock, reset, register writes, edge and query stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import rcpc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 25;
  localparam int PHASE_ITEMS = 215;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  rcpc_in_if  req_if ();
  rcpc_out_if rsp_if ();

  int          fails;
  int          pending;
  bit          steady;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  logic [15:0] coarse_now;
  logic [15:0] center_now;
  logic [15:0] thr_min_now;
  logic [15:0] timeout_now;
  logic [2:0]  thr_now;
  logic [2:0]  aux_now;

  always #4 clk = ~clk;

  rc_pulse_capture_failsafe u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  rcpc_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if),
    .fails     (fails),
    .pending   (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      stall_left <= gap_len();
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(logic mode, logic [2:0] ch, logic level, logic [15:0] fine,
                      logic [15:0] coarse);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.channel <= ch;
    req_if.level <= level;
    req_if.fine_time <= fine;
    req_if.coarse_time <= coarse;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic pin_edge(logic [2:0] ch, logic level, logic [15:0] fine, logic [15:0] coarse);
    send(MODE_EDGE, ch, level, fine, coarse);
  endtask

  task automatic query(logic [2:0] ch, logic [15:0] coarse);
    send(MODE_QUERY, ch, 1'($urandom), 16'($urandom), coarse);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_e r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] center, logic [15:0] div, logic [15:0] dead,
                           logic [15:0] thr_min, logic [2:0] thr_ch, logic [2:0] aux_ch,
                           logic [15:0] timeout);
    set_reg(REG_CENTER, center);
    set_reg(REG_DIVISOR, div);
    set_reg(REG_DEADBAND, dead);
    set_reg(REG_THR_MIN, thr_min);
    set_reg(REG_THR_CHAN, 16'(thr_ch));
    set_reg(REG_AUX_CHAN, 16'(aux_ch));
    set_reg(REG_TIMEOUT, timeout);
    cfg_we <= 1'b0;
    center_now = center;
    thr_min_now = thr_min;
    thr_now = thr_ch;
    aux_now = aux_ch;
    timeout_now = timeout;
  endtask

  task automatic step_coarse();
    if ($urandom_range(0, 99) < 92) begin
      coarse_now += 16'($urandom_range(0, int'(timeout_now) / 3));
    end else begin
      coarse_now += 16'($urandom);
    end
  endtask

  task automatic pulse(logic [2:0] ch);
    logic [15:0] fine0;
    logic [15:0] base;
    logic [15:0] w;
    fine0 = 16'($urandom);
    base = (ch == thr_now) ? thr_min_now : center_now;
    if ($urandom_range(0, 99) < 85) w = base - 16'd1200 + 16'($urandom_range(0, 2400));
    else w = 16'($urandom);
    pin_edge(ch, 1'b1, fine0, coarse_now);
    step_coarse();
    pin_edge(ch, 1'b0, fine0 + w, coarse_now);
  endtask

  task automatic random_phase(int n);
    int          sent;
    int          pick;
    int          r;
    logic [2:0]  ch;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (r < 35) ch = thr_now;
      else if (r < 65) ch = aux_now;
      else ch = 3'($urandom);
      if (pick < 60) begin
        pulse(ch);
        sent += 2;
        if ($urandom_range(0, 99) < 70) begin
          query($urandom_range(0, 1) ? ch : 3'($urandom), coarse_now);
          sent++;
        end
      end else if (pick < 85) begin
        step_coarse();
        query(3'($urandom), coarse_now);
        sent++;
      end else begin
        send(1'($urandom), 3'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER;
    cfg_data = 16'd0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_EDGE;
    req_if.channel = 3'd0;
    req_if.level = 1'b0;
    req_if.fine_time = 16'd0;
    req_if.coarse_time = 16'd0;
    steady = 1'b0;
    coarse_now = 16'd0;
    center_now = 16'd3000;
    thr_min_now = 16'd2000;
    timeout_now = 16'd20;
    thr_now = 3'd0;
    aux_now = 3'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: zero width, wrapped width, full width,
    // timeout boundary, both losses and a wrapped coarse timer.
    pin_edge(3'd0, 1'b1, 16'h0000, 16'd0);
    pin_edge(3'd0, 1'b0, 16'h0000, 16'd5);
    query(3'd0, 16'd5);
    pin_edge(3'd1, 1'b1, 16'hffff, 16'd6);
    pin_edge(3'd1, 1'b0, 16'h0bb7, 16'd10);
    query(3'd1, 16'd10);
    pin_edge(3'd2, 1'b1, 16'h0064, 16'd11);
    pin_edge(3'd2, 1'b0, 16'h0063, 16'd12);
    query(3'd2, 16'd12);
    query(3'd3, 16'd25);
    query(3'd3, 16'd26);
    pin_edge(3'd0, 1'b0, 16'h1000, 16'd40);
    query(3'd0, 16'd40);
    pin_edge(3'd1, 1'b1, 16'h8000, 16'd41);
    pin_edge(3'd1, 1'b0, 16'h8000, 16'hfff0);
    pin_edge(3'd0, 1'b0, 16'h1000, 16'hfff0);
    query(3'd7, 16'h0003);
    query(3'd0, 16'h0003);
    query(3'd1, 16'h0004);
    query(3'd1, 16'h0005);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      steady <= (phase % 3 == 1);
      case (phase)
        0: configure(16'd1500, 16'd4, 16'd10, 16'd1000, 3'd2, 3'd5, 16'd300);
        1: configure(16'hffff, 16'd1, 16'd255, 16'hffff, 3'd7, 3'd7, 16'hffff);
        2: configure(16'd0, 16'd0, 16'd0, 16'd0, 3'd3, 3'd3, 16'd0);
        3: configure(16'd3000, 16'd255, 16'd3, 16'd2000, 3'd6, 3'd0, 16'd1000);
        4: configure(16'($urandom), 16'($urandom_range(1, 255)), 16'($urandom_range(0, 255)),
                     16'($urandom), 3'($urandom), 3'($urandom),
                     16'($urandom_range(5, 2000)));
        default: configure(16'd3000, 16'd1, 16'd0, 16'd2000, 3'd0, 3'd1, 16'd20);
      endcase
      random_phase(PHASE_ITEMS);
      settle();
    end

    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
